@@ hdl/weighted_min_vruntime_scheduler_core_defines.svh @@
// assertion macros used by the asserting files
`ifndef WEIGHTED_MIN_VRUNTIME_SCHEDULER_CORE_DEFINES_SVH
`define WEIGHTED_MIN_VRUNTIME_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define WMVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wmvs assertion failed");

// next-cycle implication, quiet while in reset
`define WMVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wmvs assertion failed");

`endif

@@ hdl/wmvs_pkg.sv @@
`timescale 1ns / 1ps

package wmvs_pkg;

    localparam int ID_W  = 16;
    localparam int VR_W  = 31;
    localparam int DUR_W = 16;
    localparam int CFG_W = 16;
    localparam int DIV_W = 16;

    localparam logic [VR_W-1:0] VR_MAX = '1;

    // function codes on the input tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_WEIGHT_EVEN = 2'd0;
    localparam logic [1:0] CFG_WEIGHT_ODD  = 2'd1;
    localparam logic [1:0] CFG_SCALE_LOAD  = 2'd2;

    localparam logic [CFG_W-1:0] WEIGHT_EVEN_RST = 16'd3072;
    localparam logic [CFG_W-1:0] WEIGHT_ODD_RST  = 16'd1024;
    localparam logic [CFG_W-1:0] SCALE_LOAD_RST  = 16'd1024;

    typedef enum logic [1:0] {
        STAT_LOADED = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_RAN    = 2'd2,
        STAT_IDLE   = 2'd3
    } status_t;

    // one table entry as kept in the entry memory
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VR_W-1:0]  vr;
        logic [DUR_W-1:0] rem;
    } entry_t;

    // input word, lowest field in the lowest bits
    typedef struct packed {
        logic             pad;
        logic [DUR_W-1:0] duration;
        logic [VR_W-1:0]  start_vruntime;
        logic [ID_W-1:0]  proc_id;
    } in_word_t;

    // output word, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]       pad;
        logic [3:0]       active_count;
        logic             finished;
        logic [DUR_W-1:0] remaining;
        logic [VR_W-1:0]  vruntime_after;
        logic [VR_W-1:0]  vruntime_before;
        logic [CFG_W-1:0] weight_used;
        logic [ID_W-1:0]  ran_id;
    } out_word_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hdl/weighted_min_vruntime_scheduler_core.sv @@
`timescale 1ns / 1ps
// load: one word in, result in the output register in the cycle after; one word per cycle while
//   the output register is free or being read
// tick: a one-entry-per-cycle table scan, then the 16-step divider for the vruntime delta;
//   a tick on an empty table skips the divider
// one word in flight; input ready again once idle and the output register is free or being read
// rst_n is asynchronous, active low: clears the table valid bits, the count and the
//   state machine, and restores weight_even 3072, weight_odd 1024, scale_load 1024

`include "weighted_min_vruntime_scheduler_core_defines.svh"

module weighted_min_vruntime_scheduler_core
#(
    parameter int MAX_ENTRIES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,

    // input word stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,    // proc_id[15:0], start_vruntime[46:16], duration[62:47]
    input  logic         s_tuser,    // func: 0 load, 1 tick

    // result word stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,    // ran_id[15:0], weight_used[31:16], vruntime_before[62:32],
                                     // vruntime_after[93:63], remaining[109:94], finished[110],
                                     // active_count[114:111]
    output logic [1:0]   m_tuser,    // status

    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;  // slot index and rank
    localparam int CW = $clog2(MAX_ENTRIES + 1);                       // entry count
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PREP,
        ST_DIV,
        ST_UPD
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [15:0] weight_even_reg;
    logic [15:0] weight_odd_reg;
    logic [15:0] scale_load_reg;

    // table: valid bits and ranks in flops, the rest in the entry memory
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [IW-1:0]          rank_reg [MAX_ENTRIES];
    logic [CW-1:0]          count_reg;
    wmvs_pkg::entry_t       mem [MAX_ENTRIES];

    // scan pipeline
    logic [IW-1:0]     scan_cnt_reg;
    logic [IW-1:0]     cmp_idx_reg;
    logic              cmp_vld_reg;
    wmvs_pkg::entry_t  rd_data_reg;

    // current best candidate
    logic              best_found_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [IW-1:0]     best_rank_reg;
    wmvs_pkg::entry_t  best_reg;
    logic [15:0]       w_sel_reg;

    // output register
    logic                out_valid_reg;
    wmvs_pkg::out_word_t out_word_reg;
    wmvs_pkg::status_t   status_reg;

    wmvs_pkg::div_req_t div_req;
    wmvs_pkg::div_rsp_t div_rsp;

    wmvs_pkg::in_word_t in_word;
    logic               out_free;
    logic               in_accept;
    logic               tick_accept;
    logic               out_set;
    logic               ran_out;

    logic               free_found;
    logic [IW-1:0]      free_idx;

    logic               take;
    logic [15:0]        w_pick;
    logic [31:0]        vr_sum;
    logic [30:0]        vr_after;
    logic [15:0]        rem_new;
    logic               fin;
    logic [CW-1:0]      count_dec;
    logic [CW+3:0]      cnt_cur_ext;
    logic [CW+3:0]      cnt_inc_ext;
    logic [CW+3:0]      cnt_dec_ext;

    wmvs_pkg::out_word_t load_word;
    wmvs_pkg::out_word_t ran_word;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    wmvs_pkg::entry_t   mem_wdata;

    assign in_word     = wmvs_pkg::in_word_t'(s_tdata);
    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE) && out_free;
    assign in_accept   = s_tvalid && s_tready;
    assign tick_accept = in_accept && (s_tuser == wmvs_pkg::FUNC_TICK);
    assign cfg_ready   = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = status_reg;
    assign ran_out  = m_tvalid && (m_tuser == wmvs_pkg::STAT_RAN);

    // a result enters the output register: load, empty-table tick or update step
    assign out_set = (in_accept && (s_tuser == wmvs_pkg::FUNC_LOAD)) ||
                     ((state_reg == ST_PREP) && !best_found_reg) ||
                     (state_reg == ST_UPD);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // does the word out of the memory beat the best so far: lower vruntime, then older rank
    assign take = cmp_vld_reg && valid_reg[cmp_idx_reg] &&
                  (!best_found_reg || (rd_data_reg.vr < best_reg.vr) ||
                   ((rd_data_reg.vr == best_reg.vr) &&
                    (rank_reg[cmp_idx_reg] < best_rank_reg)));

    // weight by id parity
    assign w_pick = best_reg.id[0] ? weight_odd_reg : weight_even_reg;

    assign div_req.start    = (state_reg == ST_PREP) && best_found_reg;
    assign div_req.dividend = scale_load_reg;
    assign div_req.divisor  = w_pick;

    wmvs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // vruntime update, saturating; a zero weight saturates outright
    assign vr_sum    = {1'b0, best_reg.vr} + {16'h0000, div_rsp.quotient};
    assign vr_after  = ((w_sel_reg == '0) || (vr_sum > {1'b0, wmvs_pkg::VR_MAX})) ?
                       wmvs_pkg::VR_MAX : vr_sum[30:0];
    assign rem_new   = (best_reg.rem != '0) ? (best_reg.rem - 16'd1) : '0;
    assign fin       = (rem_new == '0);
    assign count_dec = count_reg - 1'b1;

    // entry count as reported, modulo 16
    assign cnt_cur_ext = {4'h0, count_reg};
    assign cnt_inc_ext = {4'h0, count_reg} + 1'b1;
    assign cnt_dec_ext = {4'h0, count_dec};

    // result words for a load and for a run
    always_comb
    begin
        load_word        = '0;
        load_word.ran_id = in_word.proc_id;
        load_word.active_count = cnt_cur_ext[3:0];
        if (free_found)
        begin
            load_word.vruntime_before = in_word.start_vruntime;
            load_word.vruntime_after  = in_word.start_vruntime;
            load_word.remaining       = in_word.duration;
            load_word.active_count    = cnt_inc_ext[3:0];
        end

        ran_word                 = '0;
        ran_word.ran_id          = best_reg.id;
        ran_word.weight_used     = w_sel_reg;
        ran_word.vruntime_before = best_reg.vr;
        ran_word.vruntime_after  = vr_after;
        ran_word.remaining       = rem_new;
        ran_word.finished        = fin;
        ran_word.active_count    = fin ? cnt_dec_ext[3:0] : cnt_cur_ext[3:0];
    end

    // entry memory write port: loads and the tick update
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = free_idx;
        mem_wdata = '{id: in_word.proc_id, vr: in_word.start_vruntime, rem: in_word.duration};
        if (state_reg == ST_UPD)
        begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_reg;
            mem_wdata = '{id: best_reg.id, vr: vr_after, rem: rem_new};
        end
        else if (in_accept && (s_tuser == wmvs_pkg::FUNC_LOAD) && free_found)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_data_reg <= mem[scan_cnt_reg];
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_even_reg <= wmvs_pkg::WEIGHT_EVEN_RST;
            weight_odd_reg  <= wmvs_pkg::WEIGHT_ODD_RST;
            scale_load_reg  <= wmvs_pkg::SCALE_LOAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wmvs_pkg::CFG_WEIGHT_EVEN: weight_even_reg <= cfg_data;
                wmvs_pkg::CFG_WEIGHT_ODD:  weight_odd_reg  <= cfg_data;
                wmvs_pkg::CFG_SCALE_LOAD:  scale_load_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // sequencer, table bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            scan_cnt_reg   <= '0;
        end
        else
        begin
            if (out_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (s_tuser == wmvs_pkg::FUNC_TICK)
                        begin
                            best_found_reg <= 1'b0;
                            cmp_vld_reg    <= 1'b0;
                            scan_cnt_reg   <= '0;
                            state_reg      <= ST_SCAN;
                        end
                        else
                        begin
                            out_word_reg <= load_word;
                            if (free_found)
                            begin
                                // new entry goes behind everything present
                                valid_reg[free_idx] <= 1'b1;
                                rank_reg[free_idx]  <= count_reg[IW-1:0];
                                count_reg           <= count_reg + 1'b1;
                                status_reg          <= wmvs_pkg::STAT_LOADED;
                            end
                            else
                            begin
                                status_reg <= wmvs_pkg::STAT_FULL;
                            end
                        end
                    end
                end

                ST_SCAN, ST_DRAIN:
                begin
                    if (take)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= cmp_idx_reg;
                        best_rank_reg  <= rank_reg[cmp_idx_reg];
                        best_reg       <= rd_data_reg;
                    end
                    if (state_reg == ST_SCAN)
                    begin
                        cmp_vld_reg <= 1'b1;
                        cmp_idx_reg <= scan_cnt_reg;
                        if (scan_cnt_reg == LAST_IDX)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            scan_cnt_reg <= scan_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= ST_PREP;
                    end
                end

                ST_PREP:
                begin
                    if (best_found_reg)
                    begin
                        w_sel_reg <= w_pick;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        // empty table: idle result
                        out_word_reg  <= '0;
                        status_reg    <= wmvs_pkg::STAT_IDLE;
                        state_reg     <= ST_IDLE;
                    end
                end

                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_UPD;
                    end
                end

                ST_UPD:
                begin
                    // close the gap left by the chosen entry's rank
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        if (valid_reg[i] && (IW'(i) != best_idx_reg) &&
                            (rank_reg[i] > best_rank_reg))
                        begin
                            rank_reg[i] <= rank_reg[i] - 1'b1;
                        end
                    end
                    if (fin)
                    begin
                        valid_reg[best_idx_reg] <= 1'b0;
                        count_reg               <= count_dec;
                    end
                    else
                    begin
                        // back of the line, behind equal keys
                        rank_reg[best_idx_reg] <= count_dec[IW-1:0];
                    end
                    out_word_reg <= ran_word;
                    status_reg   <= wmvs_pkg::STAT_RAN;
                    state_reg    <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // count always matches the valid bits
    `WMVS_ASSERT_NOW(a_count_matches, clk, rst_n, 1'b1, $countones(valid_reg) == int'(count_reg))
    // a tick never yields its result in the cycle after acceptance
    `WMVS_ASSERT_NEXT(a_tick_no_early, clk, rst_n, tick_accept, !m_tvalid)
    // the update step always delivers a result
    `WMVS_ASSERT_NEXT(a_upd_delivers, clk, rst_n, state_reg == ST_UPD, ran_out)
    // the divider is started only from an idle divider
    `WMVS_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)

endmodule

@@ hdl/wmvs_div.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module wmvs_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  wmvs_pkg::div_req_t req,
    output wmvs_pkg::div_rsp_t rsp
);

    localparam int W  = wmvs_pkg::DIV_W;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] step_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  div_reg;

    logic [W:0]    shifted;
    logic [W+1:0]  trial;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                div_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                // keep the partial remainder when the trial subtract borrows
                if (!trial[W+1])
                begin
                    rem_reg <= trial[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS       = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 40;
    localparam int SHOWN_ERRS  = 10;

    // index past the last register, the block drops writes to it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // one result word as it should leave the block
    typedef struct {
        wmvs_pkg::status_t   status;
        wmvs_pkg::out_word_t word;
    } sched_result_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata   = '0;
    logic         s_tuser   = wmvs_pkg::FUNC_LOAD;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [119:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = wmvs_pkg::CFG_WEIGHT_EVEN;
    logic [15:0]  cfg_data  = '0;

    weighted_min_vruntime_scheduler_core #(
        .MAX_ENTRIES (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // shadow of the process table and the registers
    logic                       tbl_valid [SLOTS];
    logic [wmvs_pkg::ID_W-1:0]  tbl_id    [SLOTS];
    logic [wmvs_pkg::VR_W-1:0]  tbl_vr    [SLOTS];
    logic [wmvs_pkg::DUR_W-1:0] tbl_rem   [SLOTS];
    int                         tbl_rank  [SLOTS];
    int                         tbl_count = 0;
    logic [wmvs_pkg::CFG_W-1:0] weight_even_reg = wmvs_pkg::WEIGHT_EVEN_RST;
    logic [wmvs_pkg::CFG_W-1:0] weight_odd_reg  = wmvs_pkg::WEIGHT_ODD_RST;
    logic [wmvs_pkg::CFG_W-1:0] scale_load_reg  = wmvs_pkg::SCALE_LOAD_RST;

    sched_result_t awaited_results [$];
    int            mismatches     = 0;
    int            cycles         = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    initial
    begin
        for (int k = 0; k < SLOTS; k++)
            tbl_valid[k] = 1'b0;
    end

    // works out the result of one accepted word and moves the shadow table on
    function automatic sched_result_t schedule_item(input logic func,
                                                    input wmvs_pkg::in_word_t w);
        sched_result_t    r;
        int               k;
        int               slot;
        int               pick;
        int               old_rank;
        logic [31:0]      wgt;
        logic [31:0]      delta;
        logic [31:0]      vr_old;
        logic [31:0]      after;
        logic             fin;

        r.status = wmvs_pkg::STAT_LOADED;
        r.word   = '0;
        if (func == wmvs_pkg::FUNC_LOAD)
        begin
            slot = -1;
            for (k = SLOTS - 1; k >= 0; k--)
                if (!tbl_valid[k])
                    slot = k;
            r.word.ran_id = w.proc_id;
            if (slot < 0)
            begin
                r.status = wmvs_pkg::STAT_FULL;
            end
            else
            begin
                tbl_valid[slot] = 1'b1;
                tbl_id[slot]    = w.proc_id;
                tbl_vr[slot]    = w.start_vruntime;
                tbl_rem[slot]   = w.duration;
                tbl_rank[slot]  = tbl_count;
                tbl_count++;
                r.word.vruntime_before = w.start_vruntime;
                r.word.vruntime_after  = w.start_vruntime;
                r.word.remaining       = w.duration;
            end
        end
        else
        begin
            // least vruntime wins, equal keys go to the oldest arrival
            pick = -1;
            for (k = 0; k < SLOTS; k++)
                if (tbl_valid[k])
                begin
                    if (pick < 0)
                        pick = k;
                    else if (tbl_vr[k] < tbl_vr[pick] ||
                             (tbl_vr[k] == tbl_vr[pick] && tbl_rank[k] < tbl_rank[pick]))
                        pick = k;
                end
            if (pick < 0)
            begin
                r.status = wmvs_pkg::STAT_IDLE;
            end
            else
            begin
                wgt    = tbl_id[pick][0] ? {16'd0, weight_odd_reg} : {16'd0, weight_even_reg};
                delta  = (wgt == 0) ? 32'hFFFF_FFFF : {16'd0, scale_load_reg} / wgt;
                vr_old = {1'b0, tbl_vr[pick]};
                after  = (delta > {1'b0, wmvs_pkg::VR_MAX} - vr_old) ?
                         {1'b0, wmvs_pkg::VR_MAX} : vr_old + delta;
                if (tbl_rem[pick] != 0)
                    tbl_rem[pick] = tbl_rem[pick] - 1'b1;
                tbl_vr[pick] = after[wmvs_pkg::VR_W-1:0];
                fin = (tbl_rem[pick] == 0);

                r.status               = wmvs_pkg::STAT_RAN;
                r.word.ran_id          = tbl_id[pick];
                r.word.weight_used     = wgt[wmvs_pkg::CFG_W-1:0];
                r.word.vruntime_before = vr_old[wmvs_pkg::VR_W-1:0];
                r.word.vruntime_after  = after[wmvs_pkg::VR_W-1:0];
                r.word.remaining       = tbl_rem[pick];
                r.word.finished        = fin;

                // pull the entry out of the arrival order, then requeue it at the back
                old_rank        = tbl_rank[pick];
                tbl_valid[pick] = 1'b0;
                for (k = 0; k < SLOTS; k++)
                    if (tbl_valid[k] && tbl_rank[k] > old_rank)
                        tbl_rank[k]--;
                if (fin)
                begin
                    tbl_count--;
                end
                else
                begin
                    tbl_rank[pick]  = tbl_count - 1;
                    tbl_valid[pick] = 1'b1;
                end
            end
        end
        r.word.active_count = 4'(tbl_count);
        return r;
    endfunction

    // entries that will stay in the table for a long time
    function automatic int long_lived();
        int n;
        n = 0;
        for (int k = 0; k < SLOTS; k++)
            if (tbl_valid[k] && tbl_rem[k] > 64)
                n++;
        return n;
    endfunction

    // input side monitor: every accepted word gets its expectation
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            awaited_results.push_back(schedule_item(s_tuser, wmvs_pkg::in_word_t'(s_tdata)));
    end

    // register write monitor
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wmvs_pkg::CFG_WEIGHT_EVEN: weight_even_reg = cfg_data;
                wmvs_pkg::CFG_WEIGHT_ODD:  weight_odd_reg  = cfg_data;
                wmvs_pkg::CFG_SCALE_LOAD:  scale_load_reg  = cfg_data;
                default: ;
            endcase
        end
    end

    // result checker, every field against the oldest expectation
    always @(posedge clk)
    begin
        sched_result_t       exp_r;
        wmvs_pkg::out_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = wmvs_pkg::out_word_t'(m_tdata);
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRS)
                    $display("error: result word with nothing awaited, status %0d id %h",
                             m_tuser, got.ran_id);
            end
            else
            begin
                exp_r = awaited_results.pop_front();
                if (m_tuser !== exp_r.status ||
                    got.ran_id !== exp_r.word.ran_id ||
                    got.weight_used !== exp_r.word.weight_used ||
                    got.vruntime_before !== exp_r.word.vruntime_before ||
                    got.vruntime_after !== exp_r.word.vruntime_after ||
                    got.remaining !== exp_r.word.remaining ||
                    got.finished !== exp_r.word.finished ||
                    got.active_count !== exp_r.word.active_count)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRS)
                    begin
                        $display("error at cycle %0d", cycles);
                        $display("  expected: st %0d id %h w %h vb %h va %h rem %h fin %b cnt %0d",
                                 exp_r.status, exp_r.word.ran_id,
                                 exp_r.word.weight_used, exp_r.word.vruntime_before,
                                 exp_r.word.vruntime_after, exp_r.word.remaining,
                                 exp_r.word.finished, exp_r.word.active_count);
                        $display("  actual:   st %0d id %h w %h vb %h va %h rem %h fin %b cnt %0d",
                                 m_tuser, got.ran_id, got.weight_used, got.vruntime_before,
                                 got.vruntime_after, got.remaining, got.finished,
                                 got.active_count);
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** weighted_min_vruntime_scheduler_core: FAILED **");
            $finish;
        end
    end

    // offers one word; starts and returns at a falling edge, valid stays up on return
    task automatic send_word(input logic func, input logic [wmvs_pkg::ID_W-1:0] id,
                             input logic [wmvs_pkg::VR_W-1:0] vr,
                             input logic [wmvs_pkg::DUR_W-1:0] dur);
        wmvs_pkg::in_word_t w;
        w.pad            = 1'b0;
        w.proc_id        = id;
        w.start_vruntime = vr;
        w.duration       = dur;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // holds the sender back until every awaited result is out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // writes all registers back to back with the block idle, then the spare index
    task automatic write_config(input logic [15:0] w_even, input logic [15:0] w_odd,
                                input logic [15:0] scale);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        idx = '{wmvs_pkg::CFG_WEIGHT_EVEN, wmvs_pkg::CFG_WEIGHT_ODD,
                wmvs_pkg::CFG_SCALE_LOAD, CFG_SPARE};
        val = '{w_even, w_odd, scale, 16'($urandom)};
        wait_drained();
        for (int n = 0; n < 4; n++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[n];
            cfg_data  <= val[n];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // idle tick, fill with ties and extremes, rejects on a full table, then eight ticks
    task automatic test_fill_and_order();
        send_word(wmvs_pkg::FUNC_TICK, 16'h0000, '0, 16'h0000);
        // zero duration, gone on first run
        send_word(wmvs_pkg::FUNC_LOAD, 16'h0002, 31'd5, 16'd0);
        send_word(wmvs_pkg::FUNC_LOAD, 16'h0003, 31'd5, 16'd2);
        send_word(wmvs_pkg::FUNC_LOAD, 16'hFFFF, wmvs_pkg::VR_MAX, 16'hFFFF);
        send_word(wmvs_pkg::FUNC_LOAD, 16'h0000, 31'd5, 16'd1);
        send_word(wmvs_pkg::FUNC_LOAD, 16'h0001, wmvs_pkg::VR_MAX - 31'd1, 16'd3);
        send_word(wmvs_pkg::FUNC_LOAD, 16'h4444, 31'd0, 16'd1);
        send_word(wmvs_pkg::FUNC_LOAD, 16'h00FE, 31'd5, 16'd3);
        send_word(wmvs_pkg::FUNC_LOAD, 16'h7FFF, 31'h1000, 16'd2);
        // table full
        send_word(wmvs_pkg::FUNC_LOAD, 16'hAAAA, 31'h2AAAAAAA, 16'h5555);
        send_word(wmvs_pkg::FUNC_LOAD, 16'h5555, 31'h55555555, 16'hAAAA);
        repeat (8)
            send_word(wmvs_pkg::FUNC_TICK, 16'($urandom), 31'($urandom), 16'($urandom));
    endtask

    // zero weight saturates, weight one with the largest scale jumps far
    task automatic test_weight_extremes();
        write_config(16'd0, 16'd1, 16'hFFFF);
        send_word(wmvs_pkg::FUNC_LOAD, 16'h0010, 31'd100, 16'd2);
        send_word(wmvs_pkg::FUNC_LOAD, 16'h0011, 31'd100, 16'd2);
        repeat (5)
            send_word(wmvs_pkg::FUNC_TICK, 16'h0000, '0, 16'h0000);
    endtask

    // random traffic shaped toward a busy table
    task automatic send_random_item();
        logic                       func;
        logic [wmvs_pkg::VR_W-1:0]  vr;
        logic [wmvs_pkg::DUR_W-1:0] dur;
        int                         roll;
        roll = $urandom_range(99, 0);
        if (tbl_count >= SLOTS)
            func = (roll < 30) ? wmvs_pkg::FUNC_LOAD : wmvs_pkg::FUNC_TICK;
        else if (tbl_count == 0)
            func = (roll < 70) ? wmvs_pkg::FUNC_LOAD : wmvs_pkg::FUNC_TICK;
        else
            func = (roll < 50) ? wmvs_pkg::FUNC_LOAD : wmvs_pkg::FUNC_TICK;

        // mostly small vruntimes so keys collide, some near the ceiling
        roll = $urandom_range(99, 0);
        if (roll < 60)
            vr = 31'($urandom_range(15, 0));
        else if (roll < 80)
            vr = wmvs_pkg::VR_MAX - 31'($urandom_range(40, 0));
        else
            vr = 31'($urandom);

        // short runs keep the table turning over; only a couple of long-lived entries
        roll = $urandom_range(99, 0);
        if (roll < 70)
            dur = 16'($urandom_range(4, 0));
        else if (roll < 97 || long_lived() >= 2)
            dur = 16'($urandom_range(40, 5));
        else
            dur = 16'($urandom);

        send_word(func, 16'($urandom), vr, dur);
    endtask

    // phases over register settings and idle patterns
    task automatic test_random_phases();
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: write_config(wmvs_pkg::WEIGHT_EVEN_RST, wmvs_pkg::WEIGHT_ODD_RST,
                                wmvs_pkg::SCALE_LOAD_RST);
                1: write_config(16'd1, 16'd1, 16'hFFFF);
                2: write_config(16'hFFFF, 16'hFFFF, 16'd0);
                3: write_config(16'd0, 16'd7, 16'd1000);
                4: write_config(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                                16'($urandom));
                5: write_config(16'd1, 16'hFFFF, 16'hFFFF);
                6: write_config(16'd3, 16'd5, 16'd100);
                default: write_config(wmvs_pkg::WEIGHT_EVEN_RST, wmvs_pkg::WEIGHT_ODD_RST,
                                      wmvs_pkg::SCALE_LOAD_RST);
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct = 38;
                    recv_stall_pct = 38;
                end
            endcase
            for (int n = 0; n < 220; n++)
            begin
                if ($urandom_range(63, 0) == 0)
                    wait_drained();
                send_random_item();
            end
        end
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_and_order();
        test_weight_extremes();
        test_random_phases();

        wait_drained();
        repeat (SETTLE)
            @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("** weighted_min_vruntime_scheduler_core: PASSED **");
        else
            $display("** weighted_min_vruntime_scheduler_core: FAILED **");
        $finish;
    end

endmodule
